// File: rtl/core/wpg_pkg.sv
// ----------------------------------------------------------------------------
// wpg_pkg
// Shared widths, angle constants, codes and the arctangent table of waypoint guidance.
// ----------------------------------------------------------------------------
`default_nettype none

package wpg_pkg;

  // Defaults for top level parameters
  localparam int unsigned MAX_WAYPOINTS_DEF = 256;
  localparam int unsigned CORDIC_STEPS_DEF  = 16;

  // Field widths
  localparam int unsigned POS_W    = 32;
  localparam int unsigned DELTA_W  = POS_W + 1;  // difference of two positions
  localparam int unsigned VEC_W    = DELTA_W + 3; // CORDIC vector with growth
  localparam int unsigned ANG_W    = 26;          // angle, 1/65536 degree
  localparam int unsigned ERR_W    = ANG_W + 1;   // difference of two angles
  localparam int unsigned RADIUS_W = 24;
  localparam int unsigned SQ_W     = 2 * RADIUS_W;
  localparam int unsigned D2_W     = SQ_W + 1;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned HDG_W    = 17;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned ITER_W   = 5;
  localparam int unsigned ATAN_ENTRIES = 24;

  // Angles in 1/65536 degree
  localparam logic signed [ERR_W-1:0] ANG_90  = ERR_W'(90 * 65536);
  localparam logic signed [ERR_W-1:0] ANG_180 = ERR_W'(180 * 65536);
  localparam logic signed [ERR_W-1:0] ANG_360 = ERR_W'(360 * 65536);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REACH_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 2'd2;

  // Input function codes
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_FIX    = 1'b1;

  // Rounded arctangent of 2^-i in 1/65536 degree
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/waypoint_heading_guidance.sv
// ----------------------------------------------------------------------------
// waypoint_heading_guidance
// Waypoint following by heading error, table held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid_i/in_ready_o. An append word (func 0) stores a
// waypoint and gives no result; appends beyond the table size are dropped. A
// position fix (func 1) gives one result word on out_valid_o / out_ready_i.
// A fix reads the active waypoint from the RAM, squares the distance with one
// shared 24x24 multiplier, compares it with the squared reach radius, and then
// runs the iterative CORDIC twice, target bearing then travel bearing. A
// waypoint inside the radius is passed; the next one is then read and steered
// at without a distance test of its own, or the fix reports finished if none
// is left. A far waypoint skips the compare, and a zero vector ends its CORDIC
// run at once. A fix that only reports finished goes straight to the output
// step. One word is worked on at a time; a new word is taken while the
// previous result still sits in the output register, and the block holds in
// its final step while the receiver stalls. Reset empties the table, rewinds
// the active waypoint and loads the register defaults; no clearing pass runs.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_heading_guidance #(
  parameter int unsigned MAX_WAYPOINTS = wpg_pkg::MAX_WAYPOINTS_DEF,
  parameter int unsigned CORDIC_STEPS  = wpg_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [wpg_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [wpg_pkg::CFG_DAT_W-1:0]         cfg_data_i,
  // input words
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  func_i,
  input  wire logic signed [wpg_pkg::POS_W-1:0]      pos_x_i,
  input  wire logic signed [wpg_pkg::POS_W-1:0]      pos_y_i,
  // result words
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       status_o,
  output logic signed [wpg_pkg::HDG_W-1:0]           steer_err_o,
  output logic [wpg_pkg::SPEED_W-1:0]                speed_o,
  output logic [wpg_pkg::IDX_W-1:0]                  waypoint_index_o
);

  localparam int unsigned AW   = $clog2(MAX_WAYPOINTS);
  localparam int unsigned CNTW = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned PW   = wpg_pkg::POS_W;
  localparam int unsigned DW   = wpg_pkg::DELTA_W;
  localparam int unsigned RW   = wpg_pkg::RADIUS_W;
  localparam int unsigned EW   = wpg_pkg::ERR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SQX, S_SQY, S_R2, S_CMP,
    S_TGT, S_TGT_WAIT, S_TRV, S_TRV_WAIT, S_WRAP, S_EMIT
  } state_e;

  state_e                      state_q;
  logic [CNTW-1:0]             count_q, active_q, active_nx;
  logic                        have_fix_q, advanced_q, fin_q;
  logic signed [PW-1:0]        px_q, py_q, prev_x_q, prev_y_q;
  logic signed [DW-1:0]        dx_q, dy_q, tdx, tdy;
  logic [wpg_pkg::SQ_W-1:0]    sqx_q, r2_q;
  logic [wpg_pkg::D2_W-1:0]    d2_q;
  logic signed [wpg_pkg::ANG_W-1:0] tgt_q;
  logic signed [wpg_pkg::HDG_W-1:0] err_q;
  logic [RW-1:0]               reach_q;
  logic [wpg_pkg::LIMIT_W-1:0] limit_q;
  logic [wpg_pkg::SPEED_W-1:0] tspeed_q;

  // RAM ports
  logic                        ram_we;
  logic [AW-1:0]               ram_raddr;
  logic [2*PW-1:0]             ram_rdata;

  // Shared multiplier
  logic [RW-1:0]               mul_a;
  logic [wpg_pkg::SQ_W-1:0]    mul_p;

  // CORDIC
  logic                        cor_start, cor_done;
  logic signed [DW-1:0]        cor_x, cor_y;
  logic signed [wpg_pkg::ANG_W-1:0] cor_z;

  logic                        in_acc, out_free;
  logic [DW-1:0]               adx, ady;
  logic                        far;
  logic signed [DW-1:0]        wx, wy;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_o || out_ready_i;
  assign active_nx   = active_q + 1'b1;

  assign ram_we = in_acc && (func_i == wpg_pkg::FUNC_APPEND) &&
                  (count_q < CNTW'(MAX_WAYPOINTS));

  // Read the active entry on accept, the next one on an advance
  assign ram_raddr = (state_q == S_CMP) ? active_nx[AW-1:0] : active_q[AW-1:0];

  wpg_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WAYPOINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({pos_y_i, pos_x_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Waypoint coordinates from the fresh read, and the travel deltas
  assign wx  = {ram_rdata[PW-1], ram_rdata[PW-1:0]};
  assign wy  = {ram_rdata[2*PW-1], ram_rdata[2*PW-1:PW]};
  assign tdx = {px_q[PW-1], px_q} - {prev_x_q[PW-1], prev_x_q};
  assign tdy = {py_q[PW-1], py_q} - {prev_y_q[PW-1], prev_y_q};

  assign adx = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign ady = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
  assign far = (adx[DW-1:RW] != '0) || (ady[DW-1:RW] != '0);

  always_comb begin
    case (state_q)
      S_SQX:   mul_a = adx[RW-1:0];
      S_SQY:   mul_a = ady[RW-1:0];
      default: mul_a = reach_q;
    endcase
  end
  assign mul_p = wpg_pkg::SQ_W'(mul_a) * wpg_pkg::SQ_W'(mul_a);

  assign cor_start = (state_q == S_TGT) || (state_q == S_TRV);
  assign cor_x     = (state_q == S_TGT) ? dx_q : tdx;
  assign cor_y     = (state_q == S_TGT) ? dy_q : tdy;

  wpg_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .done_o  (cor_done),
    .z_o     (cor_z)
  );

  // Wrap, round and clamp the heading error
  logic signed [EW-1:0]   err_raw, err_wr;
  logic signed [EW:0]     err_rs, err_rd, lim_s;
  logic signed [EW:0]     err_cl;

  always_comb begin
    err_raw = EW'(tgt_q) - EW'(cor_z);
    if (err_raw > wpg_pkg::ANG_180) begin
      err_wr = err_raw - wpg_pkg::ANG_360;
    end else if (err_raw < -wpg_pkg::ANG_180) begin
      err_wr = err_raw + wpg_pkg::ANG_360;
    end else begin
      err_wr = err_raw;
    end
    err_rs = {err_wr[EW-1], err_wr} + (EW+1)'(128);
    err_rd = err_rs >>> 8;
    lim_s  = (EW+1)'({1'b0, limit_q});
    if (err_rd > lim_s) begin
      err_cl = lim_s;
    end else if (err_rd < -lim_s) begin
      err_cl = -lim_s;
    end else begin
      err_cl = err_rd;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q  <= RW'(256);
      limit_q  <= wpg_pkg::LIMIT_W'(3840);
      tspeed_q <= wpg_pkg::SPEED_W'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wpg_pkg::REG_REACH_RADIUS: reach_q  <= cfg_data_i[RW-1:0];
        wpg_pkg::REG_STEER_LIMIT:  limit_q  <= cfg_data_i[wpg_pkg::LIMIT_W-1:0];
        wpg_pkg::REG_TARGET_SPEED: tspeed_q <= cfg_data_i[wpg_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        px_q <= pos_x_i;
        py_q <= pos_y_i;
      end
      S_LOAD: begin
        dx_q <= wx - {px_q[PW-1], px_q};
        dy_q <= wy - {py_q[PW-1], py_q};
      end
      S_SQX:      sqx_q <= mul_p;
      S_SQY:      d2_q  <= {1'b0, sqx_q} + {1'b0, mul_p};
      S_R2:       r2_q  <= mul_p;
      S_TGT_WAIT: if (cor_done) tgt_q <= cor_z;
      default: ;
    endcase
  end

  // Sequencer, control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      count_q          <= '0;
      active_q         <= '0;
      have_fix_q       <= 1'b0;
      advanced_q       <= 1'b0;
      fin_q            <= 1'b0;
      prev_x_q         <= '0;
      prev_y_q         <= '0;
      err_q            <= '0;
      out_valid_o      <= 1'b0;
      status_o         <= 1'b0;
      steer_err_o      <= '0;
      speed_o          <= '0;
      waypoint_index_o <= '0;
    end else begin
      // Raise valid when a word is loaded, drop it once taken
      if (state_q == S_EMIT && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (func_i == wpg_pkg::FUNC_APPEND) begin
              if (ram_we) count_q <= count_q + 1'b1;
            end else begin
              if (!have_fix_q) begin
                have_fix_q <= 1'b1;
                prev_x_q   <= pos_x_i;
                prev_y_q   <= pos_y_i;
              end
              advanced_q <= 1'b0;
              err_q      <= '0;
              if (active_q >= count_q) begin
                fin_q   <= 1'b1;
                state_q <= S_EMIT;
              end else begin
                fin_q   <= 1'b0;
                state_q <= S_LOAD;
              end
            end
          end
        end
        S_LOAD:  state_q <= advanced_q ? S_TGT : S_SQX;
        S_SQX:   state_q <= far ? S_TGT : S_SQY;
        S_SQY:   state_q <= S_R2;
        S_R2:    state_q <= S_CMP;
        S_CMP: begin
          if (d2_q < {1'b0, r2_q}) begin
            active_q   <= active_nx;
            advanced_q <= 1'b1;
            if (active_nx >= count_q) begin
              fin_q   <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_LOAD;
            end
          end else begin
            state_q <= S_TGT;
          end
        end
        S_TGT:      state_q <= S_TGT_WAIT;
        S_TGT_WAIT: if (cor_done) state_q <= S_TRV;
        S_TRV:      state_q <= S_TRV_WAIT;
        S_TRV_WAIT: if (cor_done) state_q <= S_WRAP;
        S_WRAP: begin
          err_q   <= wpg_pkg::HDG_W'(err_cl);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            status_o         <= fin_q;
            steer_err_o      <= err_q;
            speed_o          <= fin_q ? '0 : tspeed_q;
            waypoint_index_o <= wpg_pkg::IDX_W'(active_q);
            if (!fin_q) begin
              prev_x_q <= px_q;
              prev_y_q <= py_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wpg_ram.sv
// ----------------------------------------------------------------------------
// wpg_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wpg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/wpg_cordic.sv
// ----------------------------------------------------------------------------
// wpg_cordic
// Iterative vectoring CORDIC: atan2(y, x) in 1/65536 degree, one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wpg_cordic #(
  parameter int unsigned STEPS = wpg_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [wpg_pkg::DELTA_W-1:0]  x_i,
  input  wire logic signed [wpg_pkg::DELTA_W-1:0]  y_i,
  output logic                                     done_o,
  output logic signed [wpg_pkg::ANG_W-1:0]         z_o
);

  localparam int unsigned ITER = (STEPS > wpg_pkg::ATAN_ENTRIES) ?
                                 wpg_pkg::ATAN_ENTRIES : STEPS;
  localparam int unsigned EXT = wpg_pkg::VEC_W - wpg_pkg::DELTA_W;

  logic                                busy_q;
  logic [wpg_pkg::ITER_W-1:0]          iter_q;
  logic signed [wpg_pkg::VEC_W-1:0]    x_q, y_q;
  logic signed [wpg_pkg::VEC_W-1:0]    xe, ye, xs, ys;
  logic signed [wpg_pkg::ANG_W-1:0]    atan_v;

  assign xe     = {{EXT{x_i[wpg_pkg::DELTA_W-1]}}, x_i};
  assign ye     = {{EXT{y_i[wpg_pkg::DELTA_W-1]}}, y_i};
  assign xs     = x_q >>> iter_q;
  assign ys     = y_q >>> iter_q;
  assign atan_v = wpg_pkg::atan_entry(iter_q);

  // Pre-rotate into the right half plane, then rotate towards the x axis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      iter_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_o    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        iter_q <= '0;
        if (x_i == '0 && y_i == '0) begin
          z_o    <= '0;
          done_o <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          if (x_i[wpg_pkg::DELTA_W-1]) begin
            if (!y_i[wpg_pkg::DELTA_W-1]) begin
              x_q <= ye;
              y_q <= -xe;
              z_o <= wpg_pkg::ANG_W'(wpg_pkg::ANG_90);
            end else begin
              x_q <= -ye;
              y_q <= xe;
              z_o <= -wpg_pkg::ANG_W'(wpg_pkg::ANG_90);
            end
          end else begin
            x_q <= xe;
            y_q <= ye;
            z_o <= '0;
          end
        end
      end else if (busy_q) begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_o <= z_o + atan_v;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_o <= z_o - atan_v;
        end
        iter_q <= iter_q + 1'b1;
        if (iter_q == wpg_pkg::ITER_W'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
